// ----- hw/rtl/nbgv_pkg.sv -----
// Shared types, constants and helpers for the n-body Verlet step block.
// No dependencies; nbody_gravity_verlet_step_top and the testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package nbgv_pkg;

    // Operation codes carried in the op field of an input request
    localparam logic [2:0] OP_LOAD       = 3'd0;
    localparam logic [2:0] OP_STEP_FIRST = 3'd1;
    localparam logic [2:0] OP_STEP_NEXT  = 3'd2;
    localparam logic [2:0] OP_READ       = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;

    // Configuration register map (byte addresses)
    localparam logic [2:0]  REG_TIME_STEP = 3'd0;
    localparam logic [30:0] DT_RESET      = 31'd65536;

    // Width of the reported body index
    localparam int IDX_W = 7;

    typedef logic signed [31:0] t_q16;
    typedef t_q16 [2:0] t_vec;

    // Input request payload
    typedef struct packed {
        logic [2:0]  op;
        logic [30:0] body_mass;
        t_q16        pos_x;
        t_q16        pos_y;
        t_q16        pos_z;
        t_q16        vel_x;
        t_q16        vel_y;
        t_q16        vel_z;
        t_q16        acc_x;
        t_q16        acc_y;
        t_q16        acc_z;
    } t_in_req;

    // Result request payload
    typedef struct packed {
        logic [IDX_W-1:0] body_index;
        t_q16             out_pos_x;
        t_q16             out_pos_y;
        t_q16             out_pos_z;
        t_q16             out_vel_x;
        t_q16             out_vel_y;
        t_q16             out_vel_z;
        t_q16             out_acc_x;
        t_q16             out_acc_y;
        t_q16             out_acc_z;
        logic             is_last;
        logic             error_flag;
    } t_out_req;

    // One stored body; element 0 of each vector is x
    typedef struct packed {
        logic [30:0] mass;
        t_vec        pos;
        t_vec        vel;
        t_vec        acc;
    } t_body;

    // Clamp to the signed 32-bit range
    function automatic t_q16 sat32(input logic signed [69:0] x);
        if (x > 70'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (x < -70'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return t_q16'(x[31:0]);
        end
    endfunction

    // Magnitude of a signed word; the most negative value maps to 2^31
    function automatic logic [31:0] mag32(input t_q16 x);
        logic [31:0] u;
        u = x;
        return x[31] ? (~u + 32'd1) : u;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/nbgv_chan_if.sv -----
// Valid/ready channel carrying one request payload per handshake.
// Payload type is set per instance; used by nbody_gravity_verlet_step_top.
`timescale 1ns / 1ps
`default_nettype none

interface nbgv_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/nbody_gravity_verlet_step_top.sv -----
// N-body velocity Verlet step engine: body store, sequencer and shared arithmetic.
// Depends on nbgv_pkg and the nbgv_chan_if channel interface.
//
// Usage: input requests arrive on i_req (load, first step, next step, read all,
// clear); results leave on o_rsp through an output register. The time step is an
// APB register at byte address 0 (unsigned Q16.16, reset 1.0).
// One request is worked on at a time; i_req.ready is high only while idle, and an
// idle block takes a new request even while an earlier result waits in o_rsp.
// Load and clear: one status result, loaded into the output register once it is free.
// Read all: one result per body, in index order.
// Step: a position pass over every body, then a force pass over every ordered pair
// of bodies, then one status result. The per-pair work is set by the single shared
// 64-bit restoring divider (six quotients per pair) and the integer square root;
// all bodies live in one single-port-read memory.
// Reset empties the store (body count zero) and restores the time step; the store
// contents are not cleared. When the receiver stalls, the sequencer holds at the
// next result until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module nbody_gravity_verlet_step_top #(
    parameter int MAX_BODIES = 64
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    nbgv_chan_if.sink        i_req,
    nbgv_chan_if.source      o_rsp,
    input  wire              psel,
    input  wire              penable,
    input  wire              pwrite,
    input  wire  [2:0]       paddr,
    input  wire  [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import nbgv_pkg::*;

    localparam int IW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int CW = $clog2(MAX_BODIES + 1);

    typedef enum logic [5:0] {
        S_IDLE, S_EMIT,
        S_RSET, S_RWAIT, S_ROUT,
        S_PSET, S_PWAIT, S_PLOAD, S_PM1, S_PM1W, S_PM2, S_PM2W, S_PM3, S_PM3W,
        S_PM4, S_PWR,
        S_FSET, S_FWAIT, S_FLOAD, S_FJSEL, S_FJWAIT, S_FJDIFF,
        S_FSQ, S_FSQW, S_FSQACC, S_FSZERO, S_FSQRT,
        S_FT0, S_FT1, S_FT1W, S_FT2, S_FT3, S_FDIV, S_FNEXTJ,
        S_FUPD, S_FUPDW, S_FV2, S_FWR
    } t_state;

    // Control state
    t_state          r_state;
    t_state          r_ret;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   r_i;
    logic [CW-1:0]   r_j;
    logic [1:0]      r_comp;
    logic            r_first;
    logic            r_err;
    logic            r_ovalid;
    logic [30:0]     r_dt;
    logic [5:0]      r_dcnt;

    // Datapath registers
    t_out_req        r_out;
    t_body           r_body;
    t_body           r_rd;
    logic [IW-1:0]   r_ra;
    logic [30:0]     r_mj;
    t_q16            r_d [3];
    logic [31:0]     r_mag [3];
    logic [63:0]     r_s;
    logic [63:0]     r_sv;
    logic [63:0]     r_sr;
    logic [63:0]     r_sbit;
    logic [64:0]     r_rem;
    logic [63:0]     r_quo;
    logic [63:0]     r_dden;
    logic signed [39:0] r_sum [3];
    logic signed [47:0] r_t1;
    logic signed [33:0] r_ma;
    logic signed [33:0] r_mb;
    logic signed [67:0] r_mp;

    // Body store
    t_body           mem [MAX_BODIES];
    logic            mem_we;
    logic [IW-1:0]   mem_wa;
    t_body           mem_wd;

    // Combinational helpers
    logic            in_acc;
    logic            out_free;
    logic            out_load;
    logic            full;
    logic            i_last;
    logic [CW+IDX_W-1:0] cnt_ext;
    logic [CW+IDX_W-1:0] i_ext;
    t_out_req        stat_out;
    logic signed [32:0]  dfull [3];
    t_q16            dsat [3];
    logic [31:0]     dmag [3];
    logic [63:0]     sq_try;
    logic            sq_ge;
    logic [64:0]     div_sh;
    logic            div_ge;
    t_q16            term;
    t_q16            na;
    logic signed [32:0] aplus;
    t_q16            h;
    t_q16            pnew;
    t_q16            vnew;
    logic signed [67:0] vstep;
    t_body           in_body;

    assign in_acc   = i_req.valid && i_req.ready;
    assign out_free = !r_ovalid || o_rsp.ready;
    assign out_load = out_free && (r_state == S_EMIT || r_state == S_ROUT);
    assign full     = (r_cnt >= CW'(MAX_BODIES));
    assign i_last   = ((r_i + CW'(1)) == r_cnt);
    assign cnt_ext  = {{IDX_W{1'b0}}, r_cnt};
    assign i_ext    = {{IDX_W{1'b0}}, r_i};

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_out;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_TIME_STEP) ? {1'b0, r_dt} : 32'd0;

    // Status result for load, step and clear
    always_comb begin
        stat_out            = '0;
        stat_out.body_index = cnt_ext[IDX_W-1:0];
        stat_out.is_last    = 1'b1;
        stat_out.error_flag = r_err;
    end

    // Arithmetic feeding the sequencer
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dfull[k] = 33'(r_rd.pos[k]) - 33'(r_body.pos[k]);
            dsat[k]  = sat32(70'(dfull[k]));
            dmag[k]  = mag32(dsat[k]);
        end

        // square root digit step
        sq_try = r_sr + r_sbit;
        sq_ge  = (r_sv >= sq_try);

        // restoring divider step
        div_sh = {r_rem[63:0], r_quo[63]};
        div_ge = (div_sh >= {1'b0, r_dden});

        // one force term, truncated toward zero and clamped
        if (r_d[r_comp][31]) begin
            term = (r_quo > 64'h8000_0000) ? 32'sh8000_0000 : t_q16'(~r_quo[31:0] + 32'd1);
        end else begin
            term = (r_quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : t_q16'(r_quo[31:0]);
        end

        // new acceleration and velocity
        na    = sat32(70'(r_sum[r_comp]));
        aplus = 33'(r_body.acc[r_comp]) + 33'(na);
        vstep = r_first ? (r_mp >>> 16) : (r_mp >>> 17);
        vnew  = sat32(70'(r_body.vel[r_comp]) + 70'(vstep));

        // position update terms
        h    = sat32(70'(r_mp >>> 16));
        pnew = sat32(70'(r_body.pos[r_comp]) + 70'(r_t1) + 70'(r_mp >>> 17));
    end

    // Input payload as a store word
    always_comb begin
        in_body.mass   = i_req.data.body_mass;
        in_body.pos[0] = i_req.data.pos_x;
        in_body.pos[1] = i_req.data.pos_y;
        in_body.pos[2] = i_req.data.pos_z;
        in_body.vel[0] = i_req.data.vel_x;
        in_body.vel[1] = i_req.data.vel_y;
        in_body.vel[2] = i_req.data.vel_z;
        in_body.acc[0] = i_req.data.acc_x;
        in_body.acc[1] = i_req.data.acc_y;
        in_body.acc[2] = i_req.data.acc_z;
    end

    // Store write port: loads from idle, write-back after each pass
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_i[IW-1:0];
        mem_wd = r_body;
        if (r_state == S_IDLE) begin
            mem_we = in_acc && (i_req.data.op == OP_LOAD) && !full;
            mem_wa = r_cnt[IW-1:0];
            mem_wd = in_body;
        end else if (r_state == S_PWR || r_state == S_FWR) begin
            mem_we = 1'b1;
        end
    end

    // Body memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[r_ra];
    end

    // Shared multiplier, product registered
    always_ff @(posedge i_clk) begin
        r_mp <= r_ma * r_mb;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_dt     <= DT_RESET;
        end else begin
            if (psel && penable && pwrite && paddr == REG_TIME_STEP) begin
                r_dt <= pwdata[30:0];
            end
            // output register: set on a new result, cleared once taken
            r_ovalid <= out_load || (r_ovalid && !o_rsp.ready);

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_err   <= (i_req.data.op == OP_LOAD) && full;
                        r_i     <= '0;
                        r_first <= (i_req.data.op == OP_STEP_FIRST);
                        unique case (i_req.data.op) inside
                            OP_LOAD: begin
                                r_state <= S_EMIT;
                                if (!full) begin
                                    r_cnt <= r_cnt + CW'(1);
                                end
                            end
                            OP_STEP_FIRST, OP_STEP_NEXT: begin
                                r_state <= (r_cnt == '0) ? S_EMIT : S_PSET;
                            end
                            OP_READ: begin
                                r_state <= (r_cnt == '0) ? S_IDLE : S_RSET;
                            end
                            OP_CLEAR: begin
                                r_cnt   <= '0;
                                r_state <= S_EMIT;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end

                // single status result
                S_EMIT: begin
                    if (out_free) begin
                        r_out   <= stat_out;
                        r_state <= S_IDLE;
                    end
                end

                // read all bodies in index order
                S_RSET: begin
                    r_ra    <= r_i[IW-1:0];
                    r_state <= S_RWAIT;
                end
                S_RWAIT: r_state <= S_ROUT;
                S_ROUT: begin
                    if (out_free) begin
                        r_out.body_index <= i_ext[IDX_W-1:0];
                        r_out.out_pos_x  <= r_rd.pos[0];
                        r_out.out_pos_y  <= r_rd.pos[1];
                        r_out.out_pos_z  <= r_rd.pos[2];
                        r_out.out_vel_x  <= r_rd.vel[0];
                        r_out.out_vel_y  <= r_rd.vel[1];
                        r_out.out_vel_z  <= r_rd.vel[2];
                        r_out.out_acc_x  <= r_rd.acc[0];
                        r_out.out_acc_y  <= r_rd.acc[1];
                        r_out.out_acc_z  <= r_rd.acc[2];
                        r_out.is_last    <= i_last;
                        r_out.error_flag <= 1'b0;
                        if (i_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + CW'(1);
                            r_state <= S_RSET;
                        end
                    end
                end

                // position pass: p += v*dt + (a*dt)*dt/2
                S_PSET: begin
                    r_ra    <= r_i[IW-1:0];
                    r_state <= S_PWAIT;
                end
                S_PWAIT: r_state <= S_PLOAD;
                S_PLOAD: begin
                    r_body  <= r_rd;
                    r_comp  <= 2'd0;
                    r_state <= S_PM1;
                end
                S_PM1: begin
                    r_ma    <= 34'(r_body.vel[r_comp]);
                    r_mb    <= $signed({3'b0, r_dt});
                    r_state <= S_PM1W;
                end
                S_PM1W: r_state <= S_PM2;
                S_PM2: begin
                    r_t1    <= 48'(r_mp >>> 16);
                    r_ma    <= 34'(r_body.acc[r_comp]);
                    r_state <= S_PM2W;
                end
                S_PM2W: r_state <= S_PM3;
                S_PM3: begin
                    r_ma    <= 34'(h);
                    r_state <= S_PM3W;
                end
                S_PM3W: r_state <= S_PM4;
                S_PM4: begin
                    r_body.pos[r_comp] <= pnew;
                    if (r_comp == 2'd2) begin
                        r_state <= S_PWR;
                    end else begin
                        r_comp  <= r_comp + 2'd1;
                        r_state <= S_PM1;
                    end
                end
                S_PWR: begin
                    if (i_last) begin
                        r_i     <= '0;
                        r_state <= S_FSET;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_PSET;
                    end
                end

                // force pass for body i
                S_FSET: begin
                    r_ra    <= r_i[IW-1:0];
                    r_state <= S_FWAIT;
                end
                S_FWAIT: r_state <= S_FLOAD;
                S_FLOAD: begin
                    r_body <= r_rd;
                    for (int k = 0; k < 3; k++) begin
                        r_sum[k] <= '0;
                    end
                    r_j     <= '0;
                    r_state <= S_FJSEL;
                end
                S_FJSEL: begin
                    if (r_j == r_cnt) begin
                        r_comp  <= 2'd0;
                        r_state <= S_FUPD;
                    end else if (r_j == r_i) begin
                        r_j <= r_j + CW'(1);
                    end else begin
                        r_ra    <= r_j[IW-1:0];
                        r_state <= S_FJWAIT;
                    end
                end
                S_FJWAIT: r_state <= S_FJDIFF;
                S_FJDIFF: begin
                    for (int k = 0; k < 3; k++) begin
                        r_d[k]   <= dsat[k];
                        r_mag[k] <= dmag[k];
                    end
                    r_mj    <= r_rd.mass;
                    r_s     <= '0;
                    r_comp  <= 2'd0;
                    r_state <= S_FSQ;
                end

                // squared distance
                S_FSQ: begin
                    r_ma    <= $signed({2'b0, r_mag[r_comp]});
                    r_mb    <= $signed({2'b0, r_mag[r_comp]});
                    r_state <= S_FSQW;
                end
                S_FSQW: r_state <= S_FSQACC;
                S_FSQACC: begin
                    r_s <= r_s + r_mp[63:0];
                    if (r_comp == 2'd2) begin
                        r_state <= S_FSZERO;
                    end else begin
                        r_comp  <= r_comp + 2'd1;
                        r_state <= S_FSQ;
                    end
                end
                S_FSZERO: begin
                    if (r_s == '0) begin
                        // coincident bodies: no contribution
                        r_state <= S_FNEXTJ;
                    end else begin
                        r_sv    <= r_s;
                        r_sr    <= '0;
                        r_sbit  <= 64'h4000_0000_0000_0000;
                        r_state <= S_FSQRT;
                    end
                end

                // integer square root, one digit a cycle
                S_FSQRT: begin
                    if (sq_ge) begin
                        r_sv <= r_sv - sq_try;
                        r_sr <= (r_sr >> 1) + r_sbit;
                    end else begin
                        r_sr <= r_sr >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                    if (r_sbit == 64'd1) begin
                        r_comp  <= 2'd0;
                        r_state <= S_FT0;
                    end
                end

                // term per component: u = |d|/r, q = m*u, c = q/s
                S_FT0: begin
                    r_rem   <= '0;
                    r_quo   <= {16'b0, r_mag[r_comp], 16'b0};
                    r_dden  <= r_sr;
                    r_dcnt  <= 6'h3F;
                    r_ret   <= S_FT1;
                    r_state <= S_FDIV;
                end
                S_FT1: begin
                    r_ma    <= $signed({3'b0, r_mj});
                    r_mb    <= $signed({1'b0, r_quo[32:0]});
                    r_state <= S_FT1W;
                end
                S_FT1W: r_state <= S_FT2;
                S_FT2: begin
                    r_rem   <= '0;
                    r_quo   <= {r_mp[47:16], 32'b0};
                    r_dden  <= r_s;
                    r_dcnt  <= 6'h3F;
                    r_ret   <= S_FT3;
                    r_state <= S_FDIV;
                end
                S_FT3: begin
                    r_sum[r_comp] <= r_sum[r_comp] + 40'(term);
                    if (r_comp == 2'd2) begin
                        r_state <= S_FNEXTJ;
                    end else begin
                        r_comp  <= r_comp + 2'd1;
                        r_state <= S_FT0;
                    end
                end

                // restoring divider, one quotient bit a cycle
                S_FDIV: begin
                    if (div_ge) begin
                        r_rem <= div_sh - {1'b0, r_dden};
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= div_sh;
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                    if (r_dcnt == '0) begin
                        r_state <= r_ret;
                    end else begin
                        r_dcnt <= r_dcnt - 6'd1;
                    end
                end
                S_FNEXTJ: begin
                    r_j     <= r_j + CW'(1);
                    r_state <= S_FJSEL;
                end

                // velocity and acceleration update
                S_FUPD: begin
                    r_ma    <= r_first ? 34'(na) : 34'(aplus);
                    r_mb    <= $signed({3'b0, r_dt});
                    r_state <= S_FUPDW;
                end
                S_FUPDW: r_state <= S_FV2;
                S_FV2: begin
                    r_body.vel[r_comp] <= vnew;
                    r_body.acc[r_comp] <= na;
                    if (r_comp == 2'd2) begin
                        r_state <= S_FWR;
                    end else begin
                        r_comp  <= r_comp + 2'd1;
                        r_state <= S_FUPD;
                    end
                end
                S_FWR: begin
                    if (i_last) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_FSET;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_BODIES))
        else $error("body count beyond store depth");

    a_no_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FJWAIT) |-> (r_j != r_i))
        else $error("body paired with itself");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FDIV) |-> (r_dden != '0))
        else $error("division by zero in force term");

    a_sqrt_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FT0) |-> (r_sr[63:32] == '0 && r_sr != '0))
        else $error("distance root out of range");

endmodule

`default_nettype wire

// ----- tb/nbody_gravity_verlet_step_top_test.sv -----
// Self-checking testbench for the n-body Verlet step block: loads, steps, reads and clears
// with an in-bench predictor of the fixed-point arithmetic. Depends on nbgv_pkg, nbgv_chan_if.
`timescale 1ns / 1ps

module nbody_gravity_verlet_step_top_test;
    import nbgv_pkg::*;

    localparam int NB = 64;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    nbgv_chan_if #(.T(t_in_req))  req_if ();
    nbgv_chan_if #(.T(t_out_req)) rsp_if ();

    nbody_gravity_verlet_step_top #(.MAX_BODIES(NB)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_rsp(rsp_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    // model state
    longint unsigned dt_q;
    int              n_bodies;
    longint          m_mass[NB];
    longint          m_pos[NB][3], m_vel[NB][3], m_acc[NB][3];

    t_out_req expected_rsp[$];
    t_in_req  req_q[$];
    int       n_sent = 0, n_accepted = 0;
    int       n_fail = 0;
    int       send_idle_pct = 0, recv_stall_pct = 0;

    initial begin
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
    end

    // ---------------- arithmetic ----------------
    function automatic longint sat_w(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned abs_w(longint a);
        return a < 0 ? -a : a;
    endfunction

    function automatic longint scale_floor(longint a, longint unsigned b, int sh);
        longint unsigned p, q;
        p = abs_w(a) * b;
        q = p >> sh;
        if (a < 0) begin
            if ((p & ((64'd1 << sh) - 1)) != 0) q++;
            return -longint'(q);
        end
        return longint'(q);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint pull_term(longint d, longint unsigned m, longint unsigned r,
                                         longint unsigned s);
        longint unsigned u, q, c;
        u = (abs_w(d) << 16) / r;
        q = (m * u) >> 16;
        c = (q << 32) / s;
        if (d < 0) return c > 64'd2147483648 ? -64'sd2147483648 : -longint'(c);
        return c > 64'd2147483647 ? 64'sd2147483647 : longint'(c);
    endfunction

    task automatic advance_bodies(bit first);
        longint na[NB][3];
        longint sum[3], d[3];
        longint unsigned s, r;
        longint h;
        for (int i = 0; i < n_bodies; i++)
            for (int k = 0; k < 3; k++) begin
                h = sat_w(scale_floor(m_acc[i][k], dt_q, 16));
                m_pos[i][k] = sat_w(m_pos[i][k] + scale_floor(m_vel[i][k], dt_q, 16)
                                    + scale_floor(h, dt_q, 17));
            end
        for (int i = 0; i < n_bodies; i++) begin
            sum = '{0, 0, 0};
            for (int j = 0; j < n_bodies; j++) begin
                if (j == i) continue;
                s = 0;
                for (int k = 0; k < 3; k++) begin
                    d[k] = sat_w(m_pos[j][k] - m_pos[i][k]);
                    s += abs_w(d[k]) * abs_w(d[k]);
                end
                if (s == 0) continue;
                r = root_floor(s);
                for (int k = 0; k < 3; k++)
                    sum[k] += pull_term(d[k], m_mass[j], r, s);
            end
            for (int k = 0; k < 3; k++) na[i][k] = sat_w(sum[k]);
        end
        for (int i = 0; i < n_bodies; i++)
            for (int k = 0; k < 3; k++) begin
                if (first) m_vel[i][k] = sat_w(m_vel[i][k] + scale_floor(na[i][k], dt_q, 16));
                else m_vel[i][k] = sat_w(m_vel[i][k]
                                         + scale_floor(m_acc[i][k] + na[i][k], dt_q, 17));
                m_acc[i][k] = na[i][k];
            end
    endtask

    // Work out the results of one accepted request
    task automatic predict_request(t_in_req rq);
        t_out_req o;
        bit err;
        err = 1'b0;
        if (rq.op == OP_READ) begin
            for (int i = 0; i < n_bodies; i++) begin
                o = '0;
                o.body_index = IDX_W'(i);
                o.out_pos_x = t_q16'(m_pos[i][0]);
                o.out_pos_y = t_q16'(m_pos[i][1]);
                o.out_pos_z = t_q16'(m_pos[i][2]);
                o.out_vel_x = t_q16'(m_vel[i][0]);
                o.out_vel_y = t_q16'(m_vel[i][1]);
                o.out_vel_z = t_q16'(m_vel[i][2]);
                o.out_acc_x = t_q16'(m_acc[i][0]);
                o.out_acc_y = t_q16'(m_acc[i][1]);
                o.out_acc_z = t_q16'(m_acc[i][2]);
                o.is_last = (i == n_bodies - 1);
                expected_rsp.insert(expected_rsp.size(), o);
            end
            return;
        end
        case (rq.op)
            OP_LOAD: begin
                if (n_bodies >= NB) begin
                    err = 1'b1;
                end else begin
                    m_mass[n_bodies] = rq.body_mass;
                    m_pos[n_bodies] = '{rq.pos_x, rq.pos_y, rq.pos_z};
                    m_vel[n_bodies] = '{rq.vel_x, rq.vel_y, rq.vel_z};
                    m_acc[n_bodies] = '{rq.acc_x, rq.acc_y, rq.acc_z};
                    n_bodies++;
                end
            end
            OP_STEP_FIRST: advance_bodies(1'b1);
            OP_STEP_NEXT:  advance_bodies(1'b0);
            OP_CLEAR:      n_bodies = 0;
            default:       return;
        endcase
        o = '0;
        o.body_index = IDX_W'(n_bodies);
        o.is_last = 1'b1;
        o.error_flag = err;
        expected_rsp.insert(expected_rsp.size(), o);
    endtask

    // ---------------- drivers ----------------
    // Request driver: holds the payload while waiting, predicts on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predict_request(req_if.data);
                n_accepted++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_if.valid <= 1'b1;
                    req_if.data  <= req_q.pop_front();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    task automatic send_request(t_in_req rq);
        n_sent++;
        req_q.insert(req_q.size(), rq);
    endtask

    task automatic write_time_step(logic [30:0] v);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_TIME_STEP; pwdata <= {1'b0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        dt_q = v;
    endtask

    task automatic drain();
        while (req_q.size() != 0 || n_accepted != n_sent || expected_rsp.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_q16 rand_word(int range_bits);
        int sel;
        sel = $urandom_range(15);
        if (sel == 0) return 32'sh7FFF_FFFF;
        if (sel == 1) return 32'sh8000_0000;
        if (sel < 4) return $urandom();
        return t_q16'($signed($urandom_range((1 << range_bits) - 1)) - (1 << (range_bits - 1)));
    endfunction

    function automatic t_in_req rand_body();
        t_in_req rq;
        rq = '0;
        rq.op = OP_LOAD;
        rq.body_mass = ($urandom_range(7) == 0) ? 31'($urandom())
                                                : 31'($urandom_range(32'h0040_0000));
        rq.pos_x = rand_word(26); rq.pos_y = rand_word(26); rq.pos_z = rand_word(26);
        rq.vel_x = rand_word(20); rq.vel_y = rand_word(20); rq.vel_z = rand_word(20);
        rq.acc_x = rand_word(18); rq.acc_y = rand_word(18); rq.acc_z = rand_word(18);
        return rq;
    endfunction

    function automatic t_in_req op_only(logic [2:0] op);
        t_in_req rq;
        rq = '0;
        rq.op = op;
        return rq;
    endfunction

    // ---------------- result checker ----------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        n_fail++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_out_req g, w;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            g = rsp_if.data;
            if (expected_rsp.size() == 0) begin
                report_mismatch("unexpected result", 32'(g.body_index), 32'd0);
            end else begin
                w = expected_rsp.pop_front();
                if (g.body_index !== w.body_index)
                    report_mismatch("index", 32'(g.body_index), 32'(w.body_index));
                if (g.out_pos_x !== w.out_pos_x) report_mismatch("pos_x", g.out_pos_x, w.out_pos_x);
                if (g.out_pos_y !== w.out_pos_y) report_mismatch("pos_y", g.out_pos_y, w.out_pos_y);
                if (g.out_pos_z !== w.out_pos_z) report_mismatch("pos_z", g.out_pos_z, w.out_pos_z);
                if (g.out_vel_x !== w.out_vel_x) report_mismatch("vel_x", g.out_vel_x, w.out_vel_x);
                if (g.out_vel_y !== w.out_vel_y) report_mismatch("vel_y", g.out_vel_y, w.out_vel_y);
                if (g.out_vel_z !== w.out_vel_z) report_mismatch("vel_z", g.out_vel_z, w.out_vel_z);
                if (g.out_acc_x !== w.out_acc_x) report_mismatch("acc_x", g.out_acc_x, w.out_acc_x);
                if (g.out_acc_y !== w.out_acc_y) report_mismatch("acc_y", g.out_acc_y, w.out_acc_y);
                if (g.out_acc_z !== w.out_acc_z) report_mismatch("acc_z", g.out_acc_z, w.out_acc_z);
                if (g.is_last !== w.is_last)
                    report_mismatch("is_last", 32'(g.is_last), 32'(w.is_last));
                if (g.error_flag !== w.error_flag)
                    report_mismatch("error", 32'(g.error_flag), 32'(w.error_flag));
            end
        end
    end

    // ---------------- tests ----------------
    // Edge values, all ops, coincident bodies, empty step/read, unused ops
    task automatic test_directed();
        t_in_req rq;
        send_request(op_only(OP_READ));
        send_request(op_only(OP_STEP_FIRST));
        send_request(op_only(3'd5));
        send_request(op_only(3'd7));
        rq = op_only(OP_LOAD);
        rq.body_mass = 31'h7FFF_FFFF;
        rq.pos_x = 32'sh7FFF_FFFF; rq.pos_y = 32'sh8000_0000; rq.pos_z = 0;
        rq.vel_x = 32'sh8000_0000; rq.vel_y = 32'sh7FFF_FFFF; rq.vel_z = -1;
        rq.acc_x = 32'sh7FFF_FFFF; rq.acc_y = 32'sh8000_0000; rq.acc_z = 1;
        send_request(rq);
        rq.pos_x = 32'sh8000_0000; rq.pos_y = 32'sh7FFF_FFFF; rq.body_mass = 0;
        send_request(rq);
        // coincident pair
        rq = op_only(OP_LOAD);
        rq.body_mass = 31'h0001_0000; rq.pos_x = 32'sh0001_0000;
        send_request(rq);
        send_request(rq);
        rq.pos_x = 32'sh0003_0000; rq.pos_y = 32'sh0004_0000;
        send_request(rq);
        send_request(op_only(OP_STEP_FIRST));
        send_request(op_only(OP_STEP_NEXT));
        send_request(op_only(OP_READ));
        send_request(op_only(3'd6));
        send_request(op_only(OP_CLEAR));
        send_request(op_only(OP_READ));
        drain();
    endtask

    // Fill the store to capacity, then a refused load
    task automatic test_store_full();
        for (int i = 0; i < NB; i++) send_request(rand_body());
        send_request(rand_body());
        send_request(op_only(OP_READ));
        send_request(op_only(OP_CLEAR));
        drain();
    endtask

    // Small systems stepped a few times, under the given time step
    task automatic test_random_runs(int runs, logic [30:0] step_val);
        int nb;
        drain();
        write_time_step(step_val);
        for (int r = 0; r < runs; r++) begin
            nb = $urandom_range(4, 1);
            for (int i = 0; i < nb; i++) send_request(rand_body());
            send_request(op_only(OP_STEP_FIRST));
            repeat ($urandom_range(2)) send_request(op_only(OP_STEP_NEXT));
            if ($urandom_range(5) == 0) send_request(op_only(3'($urandom_range(7, 5))));
            send_request(op_only(OP_READ));
            send_request(op_only(OP_CLEAR));
        end
    endtask

    initial begin
        dt_q = DT_RESET;
        n_bodies = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_store_full();
        test_random_runs(3, 31'h7FFF_FFFF);
        send_idle_pct = 71;
        test_random_runs(2, 31'd0);
        send_idle_pct = 0; recv_stall_pct = 71;
        test_random_runs(3, 31'h0000_4000);
        send_idle_pct = 6; recv_stall_pct = 6;
        test_random_runs(2, 31'($urandom()));
        drain();
        if (n_fail == 0) $display("nbody_gravity_verlet_step_top verification clean");
        else $display("nbody_gravity_verlet_step_top verification failed");
        $finish;
    end

    initial begin
        #3000000;
        $display("nbody_gravity_verlet_step_top verification failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/nbgv_pkg.sv
hw/rtl/nbgv_chan_if.sv
hw/rtl/nbody_gravity_verlet_step_top.sv
tb/nbody_gravity_verlet_step_top_test.sv
